// ===== design/rvu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the power-curve table of the RMS VU meter.
package rvu_pkg;

  localparam int DATA_W     = 16;
  localparam int ADDR_W     = 4;
  localparam int PDATA_W    = 32;
  localparam int SQ_W       = 31;
  localparam int MEAN_W     = 31;
  localparam int RMS_W      = 16;
  localparam int COEF_W     = 16;
  localparam int CURVE_LOG2 = 8;
  localparam int CURVE_N    = 1 << CURVE_LOG2;
  localparam int CURVE_W    = 18;
  localparam int PROD_W     = RMS_W + DATA_W;
  localparam int POS_W      = PROD_W + CURVE_LOG2;
  localparam int FRAC_W     = 31;
  localparam int IDX_W      = POS_W - FRAC_W;
  localparam int INTERP_W   = CURVE_W + FRAC_W;
  localparam int STEP_W     = CURVE_W + COEF_W;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_GAIN    = 2'd2,
    REG_CEILING = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] attack_coef;
    logic [DATA_W-1:0] release_coef;
    logic [DATA_W-1:0] level_gain;
    logic [DATA_W-1:0] level_ceiling;
  } cfg_t;

  typedef struct packed {
    logic acc;
    logic load;
    logic div_step;
    logic sqrt_step;
    logic scale;
    logic lookup;
    logic interp;
    logic target;
    logic smooth;
    logic apply;
  } cmd_t;

  typedef logic [CURVE_W-1:0] curve_t [0:CURVE_N];

  // entry i: largest Y with Y^5 * N^3 <= i^3 * 2^81, i.e. Y <= 2^15 * (4i/N)^0.6
  function automatic curve_t curve_build();
    curve_t tab;
    logic [CURVE_W-1:0] y;
    logic [CURVE_W-1:0] t;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] n3;
    int i;
    int b;
    n3 = 128'(CURVE_N) * 128'(CURVE_N) * 128'(CURVE_N);
    for (i = 0; i <= CURVE_N; i++) begin
      y = '0;
      rhs = (128'(i) * 128'(i) * 128'(i)) << 81;
      for (b = CURVE_W - 1; b >= 0; b--) begin
        t = y | (CURVE_W'(1) << b);
        lhs = 128'(t) * 128'(t) * 128'(t) * 128'(t) * 128'(t) * n3;
        if (lhs <= rhs) y = t;
      end
      tab[i] = y;
    end
    return tab;
  endfunction

  localparam curve_t CURVE = curve_build();

endpackage

// ===== design/rms_vu_meter_ballistics.sv =====
`timescale 1ns / 1ps
// Top level of the RMS VU meter with attack and release ballistics.
// Samples are taken one per cycle; only a block's marked sample causes a result.
// vu_level is updated after the divider (one quotient bit per cycle over SUM_W bits,
// SUM_W = 30 + clog2(BLOCK_MAX+1)), 16 root steps and the scale-to-apply states.
// Until that update is written, the next marked sample is stalled; others flow on.
// Synchronous active-high reset clears sums, count, kept level and registers to defaults.
module rms_vu_meter_ballistics #(
  parameter int BLOCK_MAX = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [rvu_pkg::DATA_W-1:0] sample,
  input  logic                              last_of_block,
  output logic                              level_valid,
  input  logic                              level_stall,
  output logic [rvu_pkg::DATA_W-1:0]        vu_level,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rvu_pkg::ADDR_W-1:0]        paddr,
  input  logic [rvu_pkg::PDATA_W-1:0]       pwdata,
  output logic [rvu_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  rvu_pkg::cfg_t cfg;
  rvu_pkg::cmd_t cmd;
  logic          out_free;

  rvu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rvu_ctrl #(.BLOCK_MAX(BLOCK_MAX)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .last_of_block (last_of_block),
    .out_free      (out_free),
    .sample_stall  (sample_stall),
    .cmd           (cmd)
  );

  rvu_dp #(.BLOCK_MAX(BLOCK_MAX)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .sample      (sample),
    .level_stall (level_stall),
    .vu_level    (vu_level),
    .level_valid (level_valid),
    .out_free    (out_free)
  );

endmodule

// ===== design/rvu_regs.sv =====
`timescale 1ns / 1ps
// APB register file holding the meter's ballistics and scaling settings.
module rvu_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rvu_pkg::ADDR_W-1:0]   paddr,
  input  logic [rvu_pkg::PDATA_W-1:0]  pwdata,
  output logic [rvu_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output rvu_pkg::cfg_t                cfg
);

  localparam logic [rvu_pkg::DATA_W-1:0] ATTACK_RST  = 16'd16384;
  localparam logic [rvu_pkg::DATA_W-1:0] RELEASE_RST = 16'd5243;
  localparam logic [rvu_pkg::DATA_W-1:0] GAIN_RST    = 16'd29491;
  localparam logic [rvu_pkg::DATA_W-1:0] CEILING_RST = 16'd39322;

  rvu_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = rvu_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coef   <= ATTACK_RST;
      cfg.release_coef  <= RELEASE_RST;
      cfg.level_gain    <= GAIN_RST;
      cfg.level_ceiling <= CEILING_RST;
    end else if (wr) begin
      unique case (idx)
        rvu_pkg::REG_ATTACK:  cfg.attack_coef   <= pwdata[rvu_pkg::DATA_W-1:0];
        rvu_pkg::REG_RELEASE: cfg.release_coef  <= pwdata[rvu_pkg::DATA_W-1:0];
        rvu_pkg::REG_GAIN:    cfg.level_gain    <= pwdata[rvu_pkg::DATA_W-1:0];
        rvu_pkg::REG_CEILING: cfg.level_ceiling <= pwdata[rvu_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rvu_pkg::REG_ATTACK:  prdata = rvu_pkg::PDATA_W'(cfg.attack_coef);
      rvu_pkg::REG_RELEASE: prdata = rvu_pkg::PDATA_W'(cfg.release_coef);
      rvu_pkg::REG_GAIN:    prdata = rvu_pkg::PDATA_W'(cfg.level_gain);
      rvu_pkg::REG_CEILING: prdata = rvu_pkg::PDATA_W'(cfg.level_ceiling);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== design/rvu_dp.sv =====
`timescale 1ns / 1ps
// Datapath: square accumulator, divider, root, curve lookup and level smoothing.
module rvu_dp #(
  parameter int BLOCK_MAX = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rvu_pkg::cmd_t                     cmd,
  input  rvu_pkg::cfg_t                     cfg,
  input  logic signed [rvu_pkg::DATA_W-1:0] sample,
  input  logic                              level_stall,
  output logic [rvu_pkg::DATA_W-1:0]        vu_level,
  output logic                              level_valid,
  output logic                              out_free
);

  localparam int CNT_W = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W = rvu_pkg::SQ_W + CNT_W - 1;
  localparam int CW    = rvu_pkg::CURVE_W;
  localparam int FW    = rvu_pkg::FRAC_W;

  // accumulation
  logic [SUM_W-1:0]                   square_sum;
  logic [CNT_W-1:0]                   sample_count;
  logic signed [2*rvu_pkg::DATA_W-1:0] sq_full;
  logic                               room;
  logic [SUM_W-1:0]                   sum_add;
  logic [CNT_W-1:0]                   count_add;

  assign sq_full   = sample * sample;
  assign room      = sample_count < CNT_W'(BLOCK_MAX);
  assign sum_add   = room ? square_sum + SUM_W'(sq_full[rvu_pkg::SQ_W-1:0]) : square_sum;
  assign count_add = room ? sample_count + CNT_W'(1) : sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.load) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.acc) begin
      square_sum   <= sum_add;
      sample_count <= count_add;
    end
  end

  // restoring divider, one quotient bit per beat of div_step
  logic [SUM_W-1:0] dvd;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0]   trial;
  logic             fits;
  logic [CNT_W:0]   trial_sub;

  assign trial     = {rem, dvd[SUM_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  // integer square root, one result bit per sqrt_step
  logic [rvu_pkg::RMS_W-1:0]   root;
  logic [rvu_pkg::RMS_W-1:0]   root_bit;
  logic [rvu_pkg::RMS_W-1:0]   root_try;
  logic [2*rvu_pkg::RMS_W-1:0] root_sq;
  logic [rvu_pkg::MEAN_W-1:0]  mean;

  assign mean     = dvd[rvu_pkg::MEAN_W-1:0];
  assign root_try = root | root_bit;
  assign root_sq  = (2*rvu_pkg::RMS_W)'(root_try) * (2*rvu_pkg::RMS_W)'(root_try);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd      <= sum_add;
      dvs      <= count_add;
      rem      <= '0;
      root     <= '0;
      root_bit <= rvu_pkg::RMS_W'(1) << (rvu_pkg::RMS_W - 1);
    end else begin
      if (cmd.div_step) begin
        rem <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], fits};
      end
      if (cmd.sqrt_step) begin
        if (root_sq <= (2*rvu_pkg::RMS_W)'(mean)) root <= root_try;
        root_bit <= root_bit >> 1;
      end
    end
  end

  // curve position, table read, interpolation
  logic [rvu_pkg::PROD_W-1:0]    prod;
  logic [rvu_pkg::POS_W-1:0]     pos;
  logic [rvu_pkg::IDX_W-1:0]     idx;
  logic                          over;
  logic [rvu_pkg::CURVE_LOG2-1:0] tidx;
  logic [rvu_pkg::CURVE_LOG2:0]   tidx_up;
  logic [FW-1:0]                 tfrac;
  logic [CW-1:0]                 t0;
  logic [CW-1:0]                 t1;
  logic [FW-1:0]                 frac;
  logic [rvu_pkg::INTERP_W-1:0]  interp_prod;
  logic [CW-1:0]                 target_lvl;

  assign pos     = rvu_pkg::POS_W'(prod) << rvu_pkg::CURVE_LOG2;
  assign idx     = pos[rvu_pkg::POS_W-1:FW];
  assign over    = idx >= rvu_pkg::IDX_W'(rvu_pkg::CURVE_N);
  assign tidx    = over ? rvu_pkg::CURVE_LOG2'(rvu_pkg::CURVE_N - 1)
                        : idx[rvu_pkg::CURVE_LOG2-1:0];
  assign tidx_up = (rvu_pkg::CURVE_LOG2 + 1)'(tidx) + (rvu_pkg::CURVE_LOG2 + 1)'(1);
  assign tfrac   = over ? '1 : pos[FW-1:0];

  // smoothing
  logic [CW-1:0]                 lvl;
  logic                          rising_c;
  logic [CW-1:0]                 diff_c;
  logic [rvu_pkg::COEF_W-1:0]    coef_c;
  logic                          rising;
  logic [rvu_pkg::STEP_W-1:0]    dprod;
  logic [rvu_pkg::STEP_W-1:0]    dprod_rnd;
  logic [CW-1:0]                 delta;
  logic [CW-1:0]                 nxt;
  logic [rvu_pkg::DATA_W-1:0]    clamped;
  logic [rvu_pkg::DATA_W-1:0]    meter_level;

  assign lvl       = CW'(meter_level);
  assign rising_c  = target_lvl > lvl;
  assign diff_c    = rising_c ? target_lvl - lvl : lvl - target_lvl;
  assign coef_c    = rising_c ? cfg.attack_coef : cfg.release_coef;
  assign dprod_rnd = dprod + (rvu_pkg::STEP_W'(1) << (rvu_pkg::COEF_W - 1));
  assign delta     = dprod_rnd[rvu_pkg::STEP_W-1:rvu_pkg::COEF_W];
  assign nxt       = rising ? lvl + delta : lvl - delta;
  assign clamped   = (nxt > CW'(cfg.level_ceiling)) ? cfg.level_ceiling
                                                    : nxt[rvu_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod <= rvu_pkg::PROD_W'(root) * rvu_pkg::PROD_W'(cfg.level_gain);
    end
    if (cmd.lookup) begin
      t0   <= rvu_pkg::CURVE[tidx];
      t1   <= rvu_pkg::CURVE[tidx_up];
      frac <= tfrac;
    end
    if (cmd.interp) begin
      interp_prod <= rvu_pkg::INTERP_W'(t1 - t0) * rvu_pkg::INTERP_W'(frac);
    end
    if (cmd.target) begin
      target_lvl <= t0 + interp_prod[rvu_pkg::INTERP_W-1:FW];
    end
    if (cmd.smooth) begin
      rising <= rising_c;
      dprod  <= rvu_pkg::STEP_W'(diff_c) * rvu_pkg::STEP_W'(coef_c);
    end
    if (cmd.apply) begin
      vu_level <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meter_level <= '0;
      level_valid <= 1'b0;
    end else if (cmd.apply) begin
      meter_level <= clamped;
      level_valid <= 1'b1;
    end else if (level_valid && !level_stall) begin
      level_valid <= 1'b0;
    end
  end

  assign out_free = !level_valid || !level_stall;

endmodule

// ===== design/rvu_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the end-of-block level update.
module rvu_ctrl #(
  parameter int BLOCK_MAX = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          sample_valid,
  input  logic          last_of_block,
  input  logic          out_free,
  output logic          sample_stall,
  output rvu_pkg::cmd_t cmd
);

  localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W  = rvu_pkg::SQ_W + CNT_W - 1;
  localparam int CTR_W  = $clog2(SUM_W);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DIV    = 9'b000000010,
    S_ROOT   = 9'b000000100,
    S_SCALE  = 9'b000001000,
    S_LOOKUP = 9'b000010000,
    S_INTERP = 9'b000100000,
    S_TARGET = 9'b001000000,
    S_SMOOTH = 9'b010000000,
    S_APPLY  = 9'b100000000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CTR_W-1:0] step;
  logic [CTR_W-1:0] step_next;

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    sample_stall = last_of_block && (state != S_IDLE);
    cmd.acc      = sample_valid && !sample_stall;
    cmd.load     = cmd.acc && last_of_block;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_DIV;
          step_next  = CTR_W'(SUM_W - 1);
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == '0) begin
          state_next = S_ROOT;
          step_next  = CTR_W'(rvu_pkg::RMS_W - 1);
        end else begin
          step_next = step - CTR_W'(1);
        end
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (step == '0) state_next = S_SCALE;
        else step_next = step - CTR_W'(1);
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_INTERP;
      end
      S_INTERP: begin
        cmd.interp = 1'b1;
        state_next = S_TARGET;
      end
      S_TARGET: begin
        cmd.target = 1'b1;
        state_next = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

`ifndef NO_ASSERTIONS
  ap_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.sqrt_step, cmd.scale, cmd.lookup,
              cmd.interp, cmd.target, cmd.smooth, cmd.apply}))
    else $error("more than one datapath command at once");

  ap_load_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DIV)
    else $error("block end did not start the divider");

  ap_apply_free: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> out_free)
    else $error("result written over an untaken beat");

  ap_div_to_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == '0) |=> state == S_ROOT && step == CTR_W'(rvu_pkg::RMS_W - 1))
    else $error("divider did not hand over to the root unit");
`endif

endmodule
